// ===== rtl/cursor_array_list_assert.svh =====
// Assertion macros shared by the cursor array list RTL.
// Depends on nothing; include with the bare file name.
`ifndef CURSOR_ARRAY_LIST_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CAL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor_array_list: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor_array_list: assertion failed");

`endif

// ===== rtl/cal_pkg.sv =====
// Shared types and constants for the cursor array list.
// Used by cal_cell, cal_chain and cursor_array_list; depends on nothing.
`default_nettype none

package cal_pkg;

   localparam int CAPACITY_DEF = 16;

   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_REMOVE = 3'd1,
      ACT_START  = 3'd2,
      ACT_END    = 3'd3,
      ACT_PREV   = 3'd4,
      ACT_NEXT   = 3'd5,
      ACT_MOVE   = 3'd6,
      ACT_READ   = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      CS_IDLE  = 1'b0,
      CS_FETCH = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] item_value;
      logic [3:0]         target_position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [4:0]         list_length;
      logic [3:0]         cursor_position;
      status_type         status;
   } rsp_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/cursor_array_list.sv =====
// Cursor array list: an ordered list of signed words held in a chain of
// cells, with a cursor and navigation actions.
//
// Usage:
//   - req channel (req_valid / req_stall / req_data) carries one action per
//     transfer (insert, remove, start, end, previous, next, move, read);
//     a transfer happens when req_valid is high and req_stall is low.
//   - rsp channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
//     result per action: value, list length, cursor and status.
//   - At the transfer edge every cell shifts, loads or holds and length and
//     cursor update; in the fetch state the read port at the new cursor then
//     fetches the value, which lands in the output register once it is free.
//     A new action is taken only after the last has left the fetch state.
//   - The output register parts the two sides: a new action is taken while
//     a finished result waits. If the receiver keeps stalling, the second
//     result waits in the fetch step and req_stall stays high until the
//     output register drains.
//   - Synchronous active-high reset empties the list and sets the cursor
//     to 0; cell contents are not cleared and are only read once written.
// Depends on cal_pkg, cal_chain, cal_cell and cursor_array_list_assert.svh.
`default_nettype none

`include "cursor_array_list_assert.svh"

module cursor_array_list #(
   parameter int CAPACITY = cal_pkg::CAPACITY_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cal_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cal_pkg::rsp_type      rsp_data
);

   localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CAPACITY);

   // Control state
   cal_pkg::ctrl_state_type state_ff, state_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [POS_W-1:0]        cur_ff, cur_in;
   cal_pkg::status_type     status_ff, status_in;
   logic                    removed_ff, removed_in;
   logic signed [31:0]      removed_value_ff, removed_value_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   cal_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    load_rsp;
   cal_pkg::cell_cmd_type   cmd;
   logic signed [31:0]      rd_word;
   logic [LEN_W-1:0]        cur_ext;

   assign accept  = req_valid && !req_stall;
   assign cur_ext = LEN_W'(cur_ff);

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cal_pkg::CS_IDLE: begin
            if (accept) begin
               state_in = cal_pkg::CS_FETCH;
            end
         end
         cal_pkg::CS_FETCH: begin
            if (load_rsp) begin
               state_in = cal_pkg::CS_IDLE;
            end
         end
         default: state_in = cal_pkg::CS_IDLE;
      endcase
   end

   // FSM outputs: take a transfer only in idle, drain fetch into a free
   // (or freeing) output register.
   always_comb begin
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      unique case (state_ff)
         cal_pkg::CS_IDLE:  req_stall = 1'b0;
         cal_pkg::CS_FETCH: load_rsp  = !rsp_valid_ff || !rsp_stall;
         default: begin
            req_stall = 1'b1;
            load_rsp  = 1'b0;
         end
      endcase
   end

   // List control: new length, cursor, status and the cell command.
   always_comb begin
      len_in           = len_ff;
      cur_in           = cur_ff;
      status_in        = status_ff;
      removed_in       = removed_ff;
      removed_value_in = removed_value_ff;
      cmd              = '0;
      if (accept) begin
         status_in  = cal_pkg::ST_OK;
         removed_in = 1'b0;
         case (req_data.action)
            cal_pkg::ACT_INSERT: begin
               if (len_ff == LEN_MAX) begin
                  status_in = cal_pkg::ST_FULL;
               end else begin
                  cmd.ins = 1'b1;
                  len_in  = len_ff + 1'b1;
               end
            end
            cal_pkg::ACT_REMOVE: begin
               if (len_ff == '0) begin
                  status_in = cal_pkg::ST_EMPTY;
               end else begin
                  // Capture the word leaving the list before the shift.
                  cmd.rem          = 1'b1;
                  removed_in       = 1'b1;
                  removed_value_in = rd_word;
                  len_in           = len_ff - 1'b1;
                  // Step back when the last entry went away.
                  if ((cur_ext == len_ff - 1'b1) && (cur_ff != '0)) begin
                     cur_in = cur_ff - 1'b1;
                  end
               end
            end
            cal_pkg::ACT_MOVE: begin
               if (32'(req_data.target_position) < 32'(len_ff)) begin
                  cur_in = POS_W'(req_data.target_position);
               end else begin
                  status_in = cal_pkg::ST_RANGE;
               end
            end
            default: begin
               if (len_ff == '0) begin
                  status_in = cal_pkg::ST_EMPTY;
                  cur_in    = '0;
               end else begin
                  case (req_data.action)
                     cal_pkg::ACT_START: cur_in = '0;
                     cal_pkg::ACT_END:   cur_in = POS_W'(len_ff - 1'b1);
                     cal_pkg::ACT_PREV: begin
                        if (cur_ff != '0) begin
                           cur_in = cur_ff - 1'b1;
                        end
                     end
                     cal_pkg::ACT_NEXT: begin
                        if (cur_ext + 1'b1 < len_ff) begin
                           cur_in = cur_ff + 1'b1;
                        end
                     end
                     default: cur_in = cur_ff;
                  endcase
               end
            end
         endcase
      end
   end

   cal_chain #(
      .CAPACITY (CAPACITY),
      .POS_W    (POS_W)
   ) u_chain (
      .clock   (clock),
      .cmd     (cmd),
      .cursor  (cur_ff),
      .item    (req_data.item_value),
      .rd_word (rd_word)
   );

   // Result assembly: removed word for remove, otherwise the word now at
   // the cursor, zero on an empty list.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.list_length     = 5'(len_ff);
         rsp_data_in.cursor_position = 4'(cur_ff);
         rsp_data_in.status          = status_ff;
         if (removed_ff) begin
            rsp_data_in.value = removed_value_ff;
         end else if (len_ff == '0) begin
            rsp_data_in.value = '0;
         end else begin
            rsp_data_in.value = rd_word;
         end
      end else if (!rsp_stall) begin
         // Drop the result once it has been taken.
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cal_pkg::CS_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff        <= status_in;
      removed_ff       <= removed_in;
      removed_value_ff <= removed_value_in;
      rsp_data_ff      <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Cursor always names a stored entry, or is 0 on an empty list.
   `CAL_ASSERT_NOW(a_cursor_in_list, clock, reset, len_ff != '0, cur_ext < len_ff)
   `CAL_ASSERT_NOW(a_cursor_zero_empty, clock, reset, len_ff == '0, cur_ff == '0)
   `CAL_ASSERT_NOW(a_length_bound, clock, reset, 1'b1, len_ff <= LEN_MAX)
   // Length and cursor move only on an accepted transfer.
   `CAL_ASSERT_NEXT(a_hold_when_idle, clock, reset, !accept, $stable(len_ff) && $stable(cur_ff))
   // A drained fetch always leaves a valid result in the output register.
   `CAL_ASSERT_NEXT(a_fetch_loads_rsp, clock, reset, load_rsp, rsp_valid_ff)

endmodule

`default_nettype wire

// ===== rtl/cal_cell.sv =====
// One storage cell of the list chain: holds a word, loads the new item,
// or takes the word of its left or right neighbor. Depends on cal_pkg.
`default_nettype none

module cal_cell #(
   parameter int POS_W = 4,
   parameter int IDX   = 0
) (
   input  wire logic                  clock,
   input  wire cal_pkg::cell_cmd_type cmd,
   input  wire logic [POS_W-1:0]      cursor,
   input  wire logic signed [31:0]    item,
   input  wire logic signed [31:0]    left_word,
   input  wire logic signed [31:0]    right_word,
   output logic signed [31:0]         word
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

   logic signed [31:0] word_ff;
   logic signed [31:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.ins) begin
         if (MY_POS == cursor) begin
            word_in = item;
         end else if (MY_POS > cursor) begin
            word_in = left_word;
         end
      end else if (cmd.rem) begin
         if (MY_POS >= cursor) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

`default_nettype wire

// ===== rtl/cal_chain.sv =====
// Row of cal_cell instances linked to their neighbors, plus the single
// read port at the cursor. Depends on cal_pkg and cal_cell.
`default_nettype none

module cal_chain #(
   parameter int CAPACITY = cal_pkg::CAPACITY_DEF,
   parameter int POS_W    = 4
) (
   input  wire logic                  clock,
   input  wire cal_pkg::cell_cmd_type cmd,
   input  wire logic [POS_W-1:0]      cursor,
   input  wire logic signed [31:0]    item,
   output logic signed [31:0]         rd_word
);

   logic signed [31:0] words [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_w;
      logic signed [31:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = words[i];
      end else begin : g_left
         assign left_w = words[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w = words[i];
      end else begin : g_right
         assign right_w = words[i+1];
      end

      cal_cell #(
         .POS_W (POS_W),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cursor     (cursor),
         .item       (item),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (words[i])
      );
   end

   // The cursor always names a stored cell.
   assign rd_word = words[cursor];

endmodule

`default_nettype wire

// ===== test/tb_cursor_array_list.sv =====
// Self-checking testbench for cursor_array_list: drives list actions over the
// valid/stall request channel and checks every response against a bench-side
// list model. Depends on cal_pkg and the cursor_array_list RTL.
module tb_cursor_array_list;
   timeunit 1ns;
   timeprecision 1ps;

   import cal_pkg::*;

   localparam int LIST_DEPTH     = CAPACITY_DEF;
   localparam int IDLE_PCT       = 24;    // chance per cycle that a side idles
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
   localparam int SETTLE_CYCLES  = 8;     // wait for stray responses after the drain
   localparam int MAX_REPORTS    = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Bench copy of the list: cells, length and cursor, updated per transfer.
   logic signed [31:0] list_cells [LIST_DEPTH];
   logic [4:0]         list_length = '0;
   logic [3:0]         list_cursor = '0;

   // Responses predicted at request transfer, oldest first.
   rsp_type pending_rsp [$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   bit no_idle        = 1'b0;   // set to hold both sides busy for a stretch

   always #5 clock = ~clock;

   cursor_array_list u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Apply one action to the bench list and return the response it must give.
   // Remove reports the removed word; every other action reports the word
   // under the cursor afterwards, or zero on an empty list.
   function automatic rsp_type apply_list_action(req_type item);
      rsp_type            rsp;
      logic signed [31:0] removed_word;
      bit                 took_out;
      rsp.status   = ST_OK;
      removed_word = '0;
      took_out     = 1'b0;
      case (item.action)
         ACT_INSERT: begin
            if (list_length == LIST_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               // open a slot at the cursor, later words move one place up
               for (int i = list_length; i > list_cursor; i--)
                  list_cells[i] = list_cells[i - 1];
               list_cells[list_cursor] = item.item_value;
               list_length++;
            end
         end
         ACT_REMOVE: begin
            if (list_length == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               removed_word = list_cells[list_cursor];
               took_out     = 1'b1;
               for (int i = list_cursor; i + 1 < list_length; i++)
                  list_cells[i] = list_cells[i + 1];
               list_length--;
               // removing the tail steps the cursor back onto the new tail
               if (list_cursor >= list_length && list_cursor > 0)
                  list_cursor--;
               if (list_length == 0)
                  list_cursor = '0;
            end
         end
         ACT_MOVE: begin
            if (item.target_position < list_length)
               list_cursor = item.target_position;
            else
               rsp.status = ST_RANGE;
         end
         default: begin
            if (list_length == 0) begin
               rsp.status  = ST_EMPTY;
               list_cursor = '0;
            end else begin
               case (item.action)
                  ACT_START: list_cursor = '0;
                  ACT_END:   list_cursor = 4'(list_length - 1);
                  ACT_PREV:  if (list_cursor > 0) list_cursor--;
                  ACT_NEXT:  if (list_cursor + 1 < list_length) list_cursor++;
                  default:   ;
               endcase
            end
         end
      endcase
      if (took_out)
         rsp.value = removed_word;
      else if (list_length == 0)
         rsp.value = '0;
      else
         rsp.value = list_cells[list_cursor];
      rsp.list_length     = list_length;
      rsp.cursor_position = list_cursor;
      return rsp;
   endfunction

   // Present one action and hold it until it transfers, then log its response.
   task automatic send_action(input action_type act, input logic signed [31:0] word,
                              input logic [3:0] target);
      req_type item;
      item.action          = act;
      item.item_value      = word;
      item.target_position = target;
      // idle gap before the item; valid only drops when a gap is taken
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(apply_list_action(item));
   endtask

   // Hold the sender off until every predicted response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(11))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly targets that name a stored word, sometimes anything in range.
   function automatic logic [3:0] pick_target();
      if (list_length != 0 && $urandom_range(3) != 0)
         return 4'($urandom_range(list_length - 1));
      return 4'($urandom_range(15));
   endfunction

   // Every action but insert on an empty list, including moves to both ends of the range.
   task automatic test_empty_list();
      send_action(ACT_REMOVE, pick_word(), 4'd0);
      send_action(ACT_START,  pick_word(), 4'd0);
      send_action(ACT_END,    pick_word(), 4'd0);
      send_action(ACT_PREV,   pick_word(), 4'd0);
      send_action(ACT_NEXT,   pick_word(), 4'd0);
      send_action(ACT_READ,   pick_word(), 4'd0);
      send_action(ACT_MOVE,   pick_word(), 4'd0);
      send_action(ACT_MOVE,   pick_word(), 4'd15);
   endtask

   // Extreme words, clamped navigation, out-of-range move, tail removal and
   // removal of the only word.
   task automatic test_extremes();
      send_action(ACT_INSERT, 32'sh7FFF_FFFF, 4'd0);
      send_action(ACT_INSERT, 32'sh8000_0000, 4'd0);
      send_action(ACT_INSERT, 32'sd0,         4'd0);
      send_action(ACT_INSERT, -32'sd1,        4'd15);
      send_action(ACT_PREV,   32'sd0, 4'd0);   // already at the start
      send_action(ACT_END,    32'sd0, 4'd0);
      send_action(ACT_NEXT,   32'sd0, 4'd0);   // already at the end
      send_action(ACT_MOVE,   32'sd0, 4'd1);
      send_action(ACT_MOVE,   32'sd0, 4'd4);   // one past the tail
      send_action(ACT_READ,   32'sd0, 4'd0);
      send_action(ACT_START,  32'sd0, 4'd0);
      send_action(ACT_REMOVE, 32'sd0, 4'd0);
      send_action(ACT_END,    32'sd0, 4'd0);
      send_action(ACT_REMOVE, 32'sd0, 4'd0);   // tail: cursor steps back
      send_action(ACT_REMOVE, 32'sd0, 4'd0);   // tail again
      send_action(ACT_REMOVE, 32'sd0, 4'd0);   // only word left
   endtask

   // Fill to capacity at random cursors, push against the full list, then
   // empty it again from random positions.
   task automatic test_full_list();
      while (list_length < LIST_DEPTH) begin
         if ($urandom_range(2) == 0)
            send_action(ACT_MOVE, pick_word(), pick_target());
         send_action(ACT_INSERT, pick_word(), 4'($urandom_range(15)));
      end
      send_action(ACT_INSERT, pick_word(), 4'd0);
      send_action(ACT_END,    pick_word(), 4'd0);
      send_action(ACT_NEXT,   pick_word(), 4'd0);
      send_action(ACT_INSERT, pick_word(), 4'd0);
      send_action(ACT_MOVE,   pick_word(), 4'd15);
      while (list_length != 0) begin
         if ($urandom_range(2) == 0)
            send_action(ACT_MOVE, pick_word(), pick_target());
         send_action(ACT_REMOVE, pick_word(), 4'($urandom_range(15)));
      end
   endtask

   // Random runs that lean toward filling, emptying or churning the list,
   // so that both the full and the empty end are reached again and again.
   task automatic test_random_walk(input int item_total);
      int         sent;
      int         insert_pct;
      int         remove_pct;
      int         roll;
      action_type act;
      sent = 0;
      while (sent < item_total) begin
         case ($urandom_range(2))
            0:       begin insert_pct = 55; remove_pct = 10; end
            1:       begin insert_pct = 10; remove_pct = 55; end
            default: begin insert_pct = 30; remove_pct = 30; end
         endcase
         repeat ($urandom_range(60, 10)) begin
            roll = $urandom_range(99);
            if (roll < insert_pct)
               act = ACT_INSERT;
            else if (roll < insert_pct + remove_pct)
               act = ACT_REMOVE;
            else
               act = action_type'($urandom_range(ACT_READ, ACT_START));
            send_action(act, pick_word(), pick_target());
            sent++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input rsp_type want,
                                  input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected value=%0d length=%0d cursor=%0d status=%0d, got value=%0d length=%0d cursor=%0d status=%0d",
                  $realtime, what, want.value, want.list_length, want.cursor_position,
                  want.status, got.value, got.list_length, got.cursor_position,
                  got.status);
   endtask

   // Response side: random stall, the watchdog and the response check. All
   // channel signals are read right after the edge, so they hold the values
   // that the edge saw.
   always @(posedge clock) begin
      rsp_type want;
      rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("response with none pending", '0, rsp_data);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.value !== want.value ||
                   rsp_data.list_length !== want.list_length ||
                   rsp_data.cursor_position !== want.cursor_position ||
                   rsp_data.status !== want.status)
                  report_mismatch("response mismatch", want, rsp_data);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      drain_responses();
      test_extremes();
      drain_responses();
      test_full_list();
      drain_responses();
      test_random_walk(900);
      drain_responses();
      // long stretch with neither side idling
      no_idle <= 1'b1;
      test_random_walk(400);
      drain_responses();
      no_idle <= 1'b0;
      test_random_walk(500);
      drain_responses();
      // catch any stray response after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
